FILE: hdl/fdt_pkg.sv
// ============================================================================
// fdt_pkg
// Shared types and constants for the open-file descriptor table.
// ============================================================================
package fdt_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int FIRST_SLOT     = 2;
	localparam int OWNER_W        = 8;
	localparam int HANDLE_W       = 16;
	localparam int SLOT_OUT_W     = 4;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_REMOVE    = 3'd1,
		OP_GET       = 3'd2,
		OP_CLOSE_ALL = 3'd3,
		OP_FORK      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_CONSOLE   = 3'd3,
		ST_RANGE     = 3'd4,
		ST_NO_ROOM   = 3'd5,
		ST_SAME_TID  = 3'd6
	} status_t;

	typedef struct packed {
		logic [2:0]          op;
		logic [OWNER_W-1:0]  tid;
		logic [7:0]          slot_id;
		logic [HANDLE_W-1:0] handle_in;
		logic [OWNER_W-1:0]  new_tid;
	} item_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [HANDLE_W-1:0]   handle_out;
	} res_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

FILE: hdl/fdt_in_if.sv
// ============================================================================
// fdt_in_if
// Request channel of the descriptor table: one operation per item.
// ============================================================================
interface fdt_in_if;
	import fdt_pkg::*;

	logic                valid;
	logic                ready;
	logic [2:0]          op;
	logic [OWNER_W-1:0]  tid;
	logic [7:0]          slot_id;
	logic [HANDLE_W-1:0] handle_in;
	logic [OWNER_W-1:0]  new_tid;

	modport source (output valid, output op, output tid, output slot_id,
		output handle_in, output new_tid, input ready);
	modport sink (input valid, input op, input tid, input slot_id,
		input handle_in, input new_tid, output ready);
endinterface

FILE: hdl/fdt_out_if.sv
// ============================================================================
// fdt_out_if
// Response channel of the descriptor table: one result per request.
// ============================================================================
interface fdt_out_if;
	import fdt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [SLOT_OUT_W-1:0] slot;
	logic [HANDLE_W-1:0]   handle_out;

	modport source (output valid, output status, output slot, output handle_out,
		input ready);
	modport sink (input valid, input status, input slot, input handle_out,
		output ready);
endinterface

FILE: hdl/fdt_mem.sv
// ============================================================================
// fdt_mem
// Simple dual-port entry store: one write and one registered read per cycle.
// ============================================================================
module fdt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  fdt_pkg::mem_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: hdl/fdt_seq.sv
// ============================================================================
// fdt_seq
// Operation sequencer: valid bits, slot scans and read-modify-write of the
// entry store.
// ============================================================================
module fdt_seq #(
	parameter int TABLE_SIZE = fdt_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  fdt_pkg::item_t                item,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output fdt_pkg::res_t                 res,
	output fdt_pkg::mem_ctl_t             mem_ctl,
	output logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
	output logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
	output logic [fdt_pkg::OWNER_W+$clog2(TABLE_SIZE)+fdt_pkg::HANDLE_W-1:0] wr_data,
	input  logic [fdt_pkg::OWNER_W+$clog2(TABLE_SIZE)+fdt_pkg::HANDLE_W-1:0] rd_data
);
	import fdt_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int PTR_W  = $clog2(TABLE_SIZE + 1);
	localparam int WORD_W = OWNER_W + IDX_W + HANDLE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_MATCH,
		S_CLOSE,
		S_COUNT,
		S_COPY,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic [2:0]          op_q;
	logic [OWNER_W-1:0]  tid_q;
	logic [OWNER_W-1:0]  child_q;
	logic [IDX_W-1:0]    id_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    dst_q;
	logic [PTR_W-1:0]    left_q;
	logic [PTR_W-1:0]    owned_q;
	res_t                res_q;

	// read stage: slot whose word arrives from the store this cycle
	logic                rd_vld_s1;
	logic                rd_direct_s1;
	logic                rd_stale_s1;
	logic [IDX_W-1:0]    rd_addr_s1;

	logic [OWNER_W-1:0]  rd_owner;
	logic [IDX_W-1:0]    rd_fork;
	logic [HANDLE_W-1:0] rd_handle;
	logic [IDX_W-1:0]    ptr_idx;
	logic [IDX_W-1:0]    dst_idx;
	logic                ptr_end;
	logic                dst_end;
	logic                s1_valid;
	logic                own_s1;
	logic                match_hit;
	logic                dst_free;
	logic                add_wr;
	logic                copy_wr;
	logic                copy_stall;
	logic                scan_rd;
	logic                start_rd;
	logic                stale_nxt;
	logic                adv;
	logic                scanning;

	assign rd_owner  = rd_data[WORD_W-1 -: OWNER_W];
	assign rd_fork   = rd_data[HANDLE_W +: IDX_W];
	assign rd_handle = rd_data[HANDLE_W-1:0];
	assign ptr_idx   = ptr_q[IDX_W-1:0];
	assign dst_idx   = dst_q[IDX_W-1:0];
	assign ptr_end   = (ptr_q == PTR_W'(TABLE_SIZE));
	assign dst_end   = (dst_q == PTR_W'(TABLE_SIZE));

	assign s1_valid  = valid_q[rd_addr_s1];
	assign own_s1    = rd_vld_s1 && s1_valid && (rd_owner == tid_q) && !rd_stale_s1;
	assign match_hit = own_s1 && (rd_direct_s1 || (rd_fork == id_q));
	assign dst_free  = !dst_end && !valid_q[dst_idx];

	assign add_wr     = (state_q == S_ADD) && !ptr_end && !valid_q[ptr_idx];
	assign copy_wr    = (state_q == S_COPY) && own_s1 && dst_free;
	assign copy_stall = (state_q == S_COPY) && own_s1 && !dst_free;

	assign scanning = (state_q == S_MATCH) || (state_q == S_CLOSE) ||
		(state_q == S_COUNT) || (state_q == S_COPY);
	assign adv      = scanning && !copy_stall && !((state_q == S_MATCH) && match_hit);
	assign scan_rd  = adv && !ptr_end;
	assign start_rd = start && ((item.op == OP_REMOVE) || (item.op == OP_GET));
	// a copy landing on the slot being read: the returned word is the old one
	assign stale_nxt = copy_wr && scan_rd && (ptr_idx == dst_idx);

	always_comb begin
		mem_ctl.rd = scan_rd || start_rd;
		mem_ctl.wr = add_wr || copy_wr;
		rd_addr    = (state_q == S_IDLE) ? item.slot_id[IDX_W-1:0] : ptr_idx;
		wr_addr    = (state_q == S_ADD) ? ptr_idx : dst_idx;
		wr_data    = (state_q == S_ADD) ? {tid_q, IDX_W'(0), handle_q}
			: {child_q, rd_addr_s1, rd_handle};
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			op_q         <= '0;
			tid_q        <= '0;
			child_q      <= '0;
			id_q         <= '0;
			handle_q     <= '0;
			ptr_q        <= '0;
			dst_q        <= '0;
			left_q       <= '0;
			owned_q      <= '0;
			res_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_direct_s1 <= 1'b0;
			rd_stale_s1  <= 1'b0;
			rd_addr_s1   <= '0;
		end else begin
			// advance the read stage
			if (adv) begin
				rd_vld_s1    <= scan_rd;
				rd_direct_s1 <= 1'b0;
				rd_stale_s1  <= stale_nxt;
				rd_addr_s1   <= ptr_idx;
				if (scan_rd) begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q         <= item.op;
						tid_q        <= item.tid;
						child_q      <= item.new_tid;
						id_q         <= item.slot_id[IDX_W-1:0];
						handle_q     <= item.handle_in;
						ptr_q        <= PTR_W'(FIRST_SLOT);
						dst_q        <= PTR_W'(FIRST_SLOT);
						left_q       <= '0;
						owned_q      <= '0;
						res_q        <= '0;
						rd_vld_s1    <= 1'b0;
						rd_direct_s1 <= 1'b1;
						rd_stale_s1  <= 1'b0;
						rd_addr_s1   <= item.slot_id[IDX_W-1:0];
						unique case (item.op)
							OP_ADD: begin
								state_q <= S_ADD;
							end
							OP_REMOVE, OP_GET: begin
								if (item.slot_id < 8'(FIRST_SLOT)) begin
									res_q.status <= ST_CONSOLE;
									state_q      <= S_DONE;
								end else if ({1'b0, item.slot_id} >= 9'(TABLE_SIZE)) begin
									res_q.status <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									rd_vld_s1 <= 1'b1;
									state_q   <= S_MATCH;
								end
							end
							OP_CLOSE_ALL: begin
								state_q <= S_CLOSE;
							end
							OP_FORK: begin
								if (item.new_tid == item.tid) begin
									res_q.status <= ST_SAME_TID;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_COUNT;
								end
							end
							default: begin
								res_q.status <= ST_RANGE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_ADD: begin
					if (ptr_end) begin
						res_q.status <= ST_FULL;
						state_q      <= S_DONE;
					end else if (add_wr) begin
						valid_q[ptr_idx] <= 1'b1;
						res_q.slot       <= SLOT_OUT_W'(ptr_q);
						state_q          <= S_DONE;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				S_MATCH: begin
					if (match_hit) begin
						if (op_q == OP_REMOVE) begin
							valid_q[rd_addr_s1] <= 1'b0;
						end else begin
							res_q.handle_out <= rd_handle;
						end
						state_q <= S_DONE;
					end else if (!rd_vld_s1 && ptr_end) begin
						res_q.status <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				S_CLOSE: begin
					if (own_s1) begin
						valid_q[rd_addr_s1] <= 1'b0;
					end
					if (!rd_vld_s1 && ptr_end) begin
						state_q <= S_DONE;
					end
				end
				S_COUNT: begin
					if (rd_vld_s1) begin
						left_q  <= left_q + PTR_W'(!s1_valid);
						owned_q <= owned_q + PTR_W'(s1_valid && (rd_owner == tid_q));
					end
					if (!rd_vld_s1 && ptr_end) begin
						if (left_q < owned_q) begin
							res_q.status <= ST_NO_ROOM;
							state_q      <= S_DONE;
						end else begin
							ptr_q   <= PTR_W'(FIRST_SLOT);
							state_q <= S_COPY;
						end
					end
				end
				S_COPY: begin
					if (own_s1 && dst_end) begin
						state_q <= S_DONE;
					end else if (copy_wr) begin
						valid_q[dst_idx] <= 1'b1;
						dst_q            <= dst_q + PTR_W'(1);
					end else if (copy_stall) begin
						// hold the source, step past an occupied slot
						dst_q <= dst_q + PTR_W'(1);
					end else if (!rd_vld_s1 && ptr_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// console slots are never handed out
	a_console_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0] && !valid_q[1])
		else $error("console slot marked in use");

	// the store is only written into a free slot
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr |-> !valid_q[wr_addr])
		else $error("write into an occupied slot");

	// the room check guarantees a destination for every copied slot
	a_copy_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) && own_s1 |-> !dst_end)
		else $error("fork copy ran out of free slots");

	// a pending result is held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !res_ready |=> (state_q == S_DONE) && $stable(res_q))
		else $error("result changed before hand-off");
endmodule

FILE: hdl/open_file_descriptor_table.sv
// ============================================================================
// open_file_descriptor_table
// Per-thread open-file table: add, remove, get, close-all and fork-copy over
// TABLE_SIZE slots, with slots 0 and 1 reserved for the console.
// ============================================================================
//
//  channel  direction  handshake        payload
//  -------  ---------  ---------------  ---------------------------------------
//  req      in         valid / ready    op, tid, slot_id, handle_in, new_tid
//  rsp      out        valid / ready    status, slot, handle_out
//
//  One item is worked on at a time; req.ready is high only while the
//  sequencer is idle. Each item walks the slots one per cycle: add scans
//  the valid bits, the others read the entry store's single read port,
//  and a fork-copy holds its source while it steps past taken slots.
//  Errors found from the request alone skip the walk; every result passes
//  through the output register to rsp. Reset clears every valid bit at once;
//  store contents are left as they are. A stalled rsp holds its item in the
//  output register while the next result waits in the sequencer.
//
module open_file_descriptor_table #(
	parameter int TABLE_SIZE = fdt_pkg::TABLE_SIZE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fdt_in_if.sink    req,
	fdt_out_if.source rsp
);
	import fdt_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int WORD_W = OWNER_W + IDX_W + HANDLE_W;

	item_t             item;
	logic              start;
	logic              seq_idle;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	mem_ctl_t          mem_ctl;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd_data;

	logic              rsp_vld_q;
	res_t              rsp_q;

	// gather the request fields
	always_comb begin
		item.op        = req.op;
		item.tid       = req.tid;
		item.slot_id   = req.slot_id;
		item.handle_in = req.handle_in;
		item.new_tid   = req.new_tid;
	end

	assign req.ready = seq_idle;
	assign start     = req.valid && seq_idle;

	// entry store: owner, fork source and handle of each slot
	fdt_mem #(
		.DEPTH (TABLE_SIZE),
		.WIDTH (WORD_W)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	fdt_seq #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_data   (rd_data)
	);

	// output register: take a new result when empty or being drained
	assign res_ready = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
			rsp_q     <= '0;
		end else begin
			if (res_valid && res_ready) begin
				rsp_vld_q <= 1'b1;
				rsp_q     <= res;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = rsp_q.status;
	assign rsp.slot       = rsp_q.slot;
	assign rsp.handle_out = rsp_q.handle_out;
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the open-file descriptor table. A clocked driver
// feeds request items from a queue, a shadow table works out each reply at
// acceptance, and a clocked monitor checks every reply in order against it.
// ============================================================================
module tb;
	import fdt_pkg::*;

	localparam int NSLOT = TABLE_SIZE_DEF;

	// Op codes the block does not define; they must come back as out of range.
	localparam logic [2:0] OP_RESERVED_5 = 3'd5;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_AFTER   = 300;  // replies checked before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;  // longer than the slowest fork-copy

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	fdt_in_if  req_if();
	fdt_out_if rsp_if();

	open_file_descriptor_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	always #5 clk = ~clk;

	// Assert reset through the NBA region so every clocked process already
	// waits on its falling edge; then release it.
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Shadow table: a copy of every slot, updated as each item is accepted
	// ------------------------------------------------------------------------
	logic        slot_used   [NSLOT];
	logic [7:0]  slot_owner  [NSLOT];
	logic [4:0]  slot_src    [NSLOT];  // source slot of a fork copy, 0 if none
	logic [15:0] slot_handle [NSLOT];

	initial begin
		for (int s = 0; s < NSLOT; s++) begin
			slot_used[s]   = 1'b0;
			slot_owner[s]  = '0;
			slot_src[s]    = '0;
			slot_handle[s] = '0;
		end
	end

	// Lowest free slot above the console pair, or NSLOT when all are taken.
	function automatic int lowest_free();
		for (int s = FIRST_SLOT; s < NSLOT; s++)
			if (!slot_used[s])
				return s;
		return NSLOT;
	endfunction

	function automatic void drop_slot(int s);
		slot_used[s]   = 1'b0;
		slot_owner[s]  = '0;
		slot_src[s]    = '0;
		slot_handle[s] = '0;
	endfunction

	// Apply one request to the shadow table and return the reply it must give.
	function automatic res_t table_apply(item_t it);
		res_t r;
		int   hit;
		int   d;
		int   left;
		int   owned;
		bit   stop;
		r        = '0;
		r.status = ST_OK;
		case (it.op)
			OP_ADD: begin
				d = lowest_free();
				if (d == NSLOT) begin
					r.status = ST_FULL;
				end else begin
					slot_used[d]   = 1'b1;
					slot_owner[d]  = it.tid;
					slot_src[d]    = '0;
					slot_handle[d] = it.handle_in;
					r.slot         = d[3:0];
				end
			end
			OP_REMOVE, OP_GET: begin
				if (it.slot_id < FIRST_SLOT) begin
					r.status = ST_CONSOLE;
				end else if (it.slot_id >= NSLOT) begin
					r.status = ST_RANGE;
				end else begin
					// own slot first, else the first copy forked from it
					hit = NSLOT;
					if (slot_used[it.slot_id] && slot_owner[it.slot_id] == it.tid) begin
						hit = it.slot_id;
					end else begin
						for (int s = FIRST_SLOT; s < NSLOT; s++)
							if (hit == NSLOT && slot_used[s] && slot_owner[s] == it.tid
								&& slot_src[s] == it.slot_id)
								hit = s;
					end
					if (hit == NSLOT)
						r.status = ST_NOT_FOUND;
					else if (it.op == OP_REMOVE)
						drop_slot(hit);
					else
						r.handle_out = slot_handle[hit];
				end
			end
			OP_CLOSE_ALL: begin
				for (int s = FIRST_SLOT; s < NSLOT; s++)
					if (slot_used[s] && slot_owner[s] == it.tid)
						drop_slot(s);
			end
			OP_FORK: begin
				if (it.new_tid == it.tid) begin
					r.status = ST_SAME_TID;
				end else begin
					left  = 0;
					owned = 0;
					for (int s = FIRST_SLOT; s < NSLOT; s++) begin
						if (!slot_used[s])
							left++;
						else if (slot_owner[s] == it.tid)
							owned++;
					end
					if (left < owned) begin
						r.status = ST_NO_ROOM;
					end else begin
						stop = 1'b0;
						for (int s = FIRST_SLOT; s < NSLOT; s++) begin
							if (!stop && slot_used[s] && slot_owner[s] == it.tid) begin
								d = lowest_free();
								if (d == NSLOT) begin
									stop = 1'b1;
								end else begin
									slot_used[d]   = 1'b1;
									slot_owner[d]  = it.new_tid;
									slot_src[d]    = s[4:0];
									slot_handle[d] = slot_handle[s];
								end
							end
						end
					end
				end
			end
			default: r.status = ST_RANGE;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	item_t request_queue[$];
	res_t  expected_replies[$];
	int    n_queued = 0;
	bit    touched[256];  // threads that may own slots and need clearing

	function automatic void queue_op(logic [2:0] op, logic [7:0] tid, logic [7:0] id,
		logic [15:0] handle, logic [7:0] child);
		item_t it;
		it.op        = op;
		it.tid       = tid;
		it.slot_id   = id;
		it.handle_in = handle;
		it.new_tid   = child;
		request_queue.push_back(it);
		n_queued++;
		if (op == OP_ADD)
			touched[tid] = 1'b1;
		if (op == OP_FORK)
			touched[child] = 1'b1;
	endfunction

	function automatic logic [7:0] pick_tid();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 8'h00;
		if (r < 24)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly a slot that can exist; now and then any id at all.
	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(FIRST_SLOT, NSLOT - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// One episode: clear the threads left over, then a burst of work for a
	// small pool of threads so that adds, matches and forks keep meeting.
	function automatic void run_episode();
		logic [7:0] pool[3];
		logic [7:0] who;
		int         len;
		int         r;
		for (int t = 0; t < 256; t++) begin
			if (touched[t]) begin
				touched[t] = 1'b0;
				queue_op(OP_CLOSE_ALL, 8'(t), 8'($urandom), 16'($urandom), 8'($urandom));
			end
		end
		foreach (pool[k])
			pool[k] = pick_tid();
		len = $urandom_range(20, 60);
		repeat (len) begin
			who = pool[$urandom_range(0, 2)];
			r   = $urandom_range(0, 99);
			if (r < 32)
				queue_op(OP_ADD, who, 8'($urandom), 16'($urandom), 8'($urandom));
			else if (r < 52)
				queue_op(OP_REMOVE, who, pick_id(), 16'($urandom), 8'($urandom));
			else if (r < 74)
				queue_op(OP_GET, who, pick_id(), 16'($urandom), 8'($urandom));
			else if (r < 86)
				queue_op(OP_FORK, who, 8'($urandom), 16'($urandom),
					pool[$urandom_range(0, 2)]);
			else if (r < 91)
				queue_op(OP_CLOSE_ALL, who, 8'($urandom), 16'($urandom), 8'($urandom));
			else
				queue_op(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
					16'($urandom), 8'($urandom));
		end
	endfunction

	initial begin
		int directed;
		// Console and out-of-range ids, an empty table, unused op codes
		queue_op(OP_GET,       8'h10, 8'd0,   16'h1234, 8'h00);
		queue_op(OP_REMOVE,    8'h10, 8'd1,   16'h1234, 8'h00);
		queue_op(OP_GET,       8'h10, 8'd16,  16'h0000, 8'h00);
		queue_op(OP_REMOVE,    8'h10, 8'd255, 16'hFFFF, 8'hFF);
		queue_op(OP_GET,       8'h10, 8'd2,   16'h0000, 8'h00);
		queue_op(OP_RESERVED_5, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		queue_op(OP_RESERVED_7, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_op(OP_CLOSE_ALL, 8'h33, 8'd0,   16'h0000, 8'h00);
		// Extreme owners and handles land in slots 2, 3 and 4
		queue_op(OP_ADD,       8'h00, 8'd0,   16'h0000, 8'h00);
		queue_op(OP_ADD,       8'hFF, 8'd0,   16'hFFFF, 8'h00);
		queue_op(OP_ADD,       8'h5A, 8'd0,   16'hA5A5, 8'h00);
		queue_op(OP_GET,       8'hFF, 8'd3,   16'h0000, 8'h00);
		// Fork to self, then a real fork, and a lookup and a removal through the copy
		queue_op(OP_FORK,      8'hFF, 8'd0,   16'h0000, 8'hFF);
		queue_op(OP_FORK,      8'h00, 8'd0,   16'h0000, 8'h07);
		queue_op(OP_GET,       8'h07, 8'd2,   16'h0000, 8'h00);
		queue_op(OP_REMOVE,    8'h07, 8'd2,   16'h0000, 8'h00);
		// Fill the table: five adds, a fork of all five, one more add
		repeat (5)
			queue_op(OP_ADD, 8'h01, 8'd0, 16'($urandom), 8'h00);
		queue_op(OP_FORK,      8'h01, 8'd0,   16'h0000, 8'h02);
		queue_op(OP_ADD,       8'h03, 8'd0,   16'hC3C3, 8'h00);
		// Table full, and a fork with too little room
		queue_op(OP_ADD,       8'h03, 8'd0,   16'h3C3C, 8'h00);
		queue_op(OP_FORK,      8'h01, 8'd0,   16'h0000, 8'h09);
		directed = n_queued;
		while (n_queued < directed + RANDOM_ITEMS)
			run_episode();
	end

	// ------------------------------------------------------------------------
	// Driver: offer queued items, hold each until taken, idle in between
	// ------------------------------------------------------------------------
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	int    n_sent   = 0;
	int    gap_left = 0;
	bit    offering;
	item_t taken;
	item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid     <= 1'b0;
			req_if.op        <= '0;
			req_if.tid       <= '0;
			req_if.slot_id   <= '0;
			req_if.handle_in <= '0;
			req_if.new_tid   <= '0;
			gap_left = 0;
		end else begin
			offering = req_if.valid;
			// Predict from what the block actually saw on the accepting edge
			if (req_if.valid && req_if.ready) begin
				taken.op        = req_if.op;
				taken.tid       = req_if.tid;
				taken.slot_id   = req_if.slot_id;
				taken.handle_in = req_if.handle_in;
				taken.new_tid   = req_if.new_tid;
				expected_replies.push_back(table_apply(taken));
				n_sent++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					next_item = request_queue.pop_front();
					req_if.valid     <= 1'b1;
					req_if.op        <= next_item.op;
					req_if.tid       <= next_item.tid;
					req_if.slot_id   <= next_item.slot_id;
					req_if.handle_in <= next_item.handle_in;
					req_if.new_tid   <= next_item.new_tid;
					// every fourth stretch of 128 items runs back to back
					gap_left = ((n_sent / 128) % 4 == 2) ? 0 : draw_gap();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off to back the block up
	// ------------------------------------------------------------------------
	int n_checked  = 0;
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_checked >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left = 0;
		end else if (hold_left > 0) begin
			rsp_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
			if (rsp_if.valid && rsp_if.ready)
				stall_left = ((n_checked / 128) % 4 == 1) ? 0 : draw_gap();
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each reply with the oldest prediction
	// ------------------------------------------------------------------------
	int   n_errors = 0;
	res_t want;

	function automatic void flag_error(string what, res_t exp_r);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s: expected status=%0d slot=%0d handle=%h, got status=%0d slot=%0d handle=%h",
				$realtime, what, exp_r.status, exp_r.slot, exp_r.handle_out,
				rsp_if.status, rsp_if.slot, rsp_if.handle_out);
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			n_checked <= n_checked + 1;
			if (expected_replies.size() == 0) begin
				flag_error("reply with nothing outstanding", '0);
			end else begin
				want = expected_replies.pop_front();
				if (rsp_if.status !== want.status || rsp_if.slot !== want.slot
					|| rsp_if.handle_out !== want.handle_out)
					flag_error("reply mismatch", want);
			end
		end
	end

	// ------------------------------------------------------------------------
	// End of run
	// ------------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		// wait for the queue to empty, then for every reply to come home
		while (n_sent < n_queued)
			@(posedge clk);
		while (expected_replies.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard limit well beyond the slowest legal run
	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
